FILE: hdl/psm_pkg.sv
`timescale 1ns / 1ps

package psm_pkg;

  localparam int FLD_W = 16;
  localparam int CNT_W = 13;
  localparam int CW    = 17;
  localparam int IW    = 9;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_CHK_RD,
    S_CHK_EV,
    S_MARK,
    S_CNT,
    S_QWAIT,
    S_RESP
  } state_t;

endpackage

FILE: hdl/psm_ram.sv
`timescale 1ns / 1ps

module psm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/prime_sieve_membership_top.sv
`timescale 1ns / 1ps
// channel   direction  beat payload                                   handshake
// in        input      in_operation, in_value                         in_valid / in_ready
// out       output     out_is_prime, out_prime_count, out_out_of_range out_valid / out_ready
// cfg       input      cfg_wr_data (limit)                            cfg_wr_en, no wait
//
// query: answered from idle when the answer needs no map read, else through a wait state after the single map read
// build: lim+1 fill writes, then a read and a test per base i with i*i <= lim, and for
//   a base still prime one write per multiple cleared, then a counting pass
//   of one read per entry 2..lim; all on the one map ram port pair
// reset clears control state only; an unbuilt map or an entry above the last build
//   limit reads not prime through a build flag and limit register, no clearing pass
// a result held by out_ready low parks in a response register; in_ready stays low meanwhile

module prime_sieve_membership_top #(
  parameter int MAX_VALUE = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_operation,
  input  logic [psm_pkg::FLD_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_is_prime,
  output logic [psm_pkg::CNT_W-1:0] out_prime_count,
  output logic                      out_out_of_range,
  input  logic                      cfg_wr_en,
  input  logic [psm_pkg::FLD_W-1:0] cfg_wr_data
);

  import psm_pkg::*;

  localparam int AW = $clog2(MAX_VALUE);
  localparam logic [FLD_W-1:0] LIM_MAX =
    (MAX_VALUE - 1 > 65535) ? {FLD_W{1'b1}} : FLD_W'(MAX_VALUE - 1);

  state_t            state_r, state_nxt;
  logic [FLD_W-1:0]  cfg_limit_r;
  logic              built_r, built_nxt;
  logic [FLD_W-1:0]  built_lim_r, built_lim_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     sq_r, sq_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  primes_found_r, primes_found_nxt;
  logic              res_is_prime_r, res_is_prime_nxt;
  logic              res_oor_r, res_oor_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_prime_r, out_is_prime_nxt;
  logic              out_oor_r, out_oor_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [0:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [0:0]        mem_rdata;

  logic [FLD_W-1:0]  lim_eff;
  logic [CW-1:0]     blim;
  logic              in_acc;
  logic              load_ok;
  logic              q_oor;
  logic              q_direct;
  logic              fill_last;
  logic              sieve_done;
  logic              j_in;
  logic              idx_in;
  logic              cnt_done;

  assign lim_eff    = (cfg_limit_r > LIM_MAX) ? LIM_MAX : cfg_limit_r;
  assign blim       = CW'(built_lim_r);
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign load_ok    = !out_valid_r || out_ready;
  assign q_oor      = in_value > lim_eff;
  assign q_direct   = q_oor || !built_r || (in_value > built_lim_r);
  assign fill_last  = (idx_r == blim);
  assign sieve_done = (sq_r > blim);
  assign j_in       = (j_r <= blim);
  assign idx_in     = (idx_r <= blim);
  assign cnt_done   = !idx_in && !pend_r;

  psm_ram #(
    .WIDTH(1),
    .DEPTH(MAX_VALUE)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_BUILD) begin
            state_nxt = S_FILL;
          end else if (!q_direct) begin
            state_nxt = S_QWAIT;
          end else if (!load_ok) begin
            state_nxt = S_RESP;
          end
        end
      end
      S_FILL:   if (fill_last) state_nxt = S_CHK_RD;
      S_CHK_RD: state_nxt = sieve_done ? S_CNT : S_CHK_EV;
      S_CHK_EV: state_nxt = mem_rdata[0] ? S_MARK : S_CHK_RD;
      S_MARK:   if (!j_in) state_nxt = S_CHK_RD;
      S_CNT:    if (cnt_done) state_nxt = S_RESP;
      S_QWAIT:  state_nxt = load_ok ? S_IDLE : S_RESP;
      S_RESP:   if (load_ok) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    built_nxt        = built_r;
    built_lim_nxt    = built_lim_r;
    idx_nxt          = idx_r;
    i_nxt            = i_r;
    sq_nxt           = sq_r;
    j_nxt            = j_r;
    pend_nxt         = pend_r;
    cnt_nxt          = cnt_r;
    primes_found_nxt = primes_found_r;
    res_is_prime_nxt = res_is_prime_r;
    res_oor_nxt      = res_oor_r;
    out_load         = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    out_oor_nxt      = out_oor_r;
    out_count_nxt    = out_count_r;
    mem_we           = 1'b0;
    mem_waddr        = AW'(idx_r);
    mem_wdata        = 1'b0;
    mem_raddr        = AW'(idx_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_BUILD) begin
            built_nxt     = 1'b1;
            built_lim_nxt = lim_eff;
            idx_nxt       = '0;
          end else begin
            mem_raddr        = AW'(in_value);
            res_is_prime_nxt = 1'b0;
            res_oor_nxt      = q_oor;
            if (q_direct && load_ok) begin
              out_load         = 1'b1;
              out_is_prime_nxt = 1'b0;
              out_oor_nxt      = q_oor;
              out_count_nxt    = primes_found_r;
            end
          end
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = (idx_r >= CW'(2)) ? 1'b1 : 1'b0;
        idx_nxt   = idx_r + CW'(1);
        i_nxt     = IW'(2);
        sq_nxt    = CW'(4);
      end
      S_CHK_RD: begin
        mem_raddr = AW'(i_r);
        idx_nxt   = CW'(2);
        pend_nxt  = 1'b0;
        cnt_nxt   = '0;
      end
      S_CHK_EV: begin
        if (mem_rdata[0]) begin
          j_nxt = sq_r;
        end else begin
          i_nxt  = i_r + IW'(1);
          sq_nxt = sq_r + CW'({i_r, 1'b0}) + CW'(1);
        end
      end
      S_MARK: begin
        if (j_in) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(j_r);
          mem_wdata = 1'b0;
          j_nxt     = j_r + CW'(i_r);
        end else begin
          i_nxt  = i_r + IW'(1);
          sq_nxt = sq_r + CW'({i_r, 1'b0}) + CW'(1);
        end
      end
      S_CNT: begin
        mem_raddr = AW'(idx_r);
        pend_nxt  = idx_in;
        if (idx_in) begin
          idx_nxt = idx_r + CW'(1);
        end
        if (pend_r) begin
          cnt_nxt = cnt_r + CNT_W'(mem_rdata[0]);
        end
        if (cnt_done) begin
          primes_found_nxt = cnt_r;
          res_is_prime_nxt = 1'b0;
          res_oor_nxt      = 1'b0;
        end
      end
      S_QWAIT: begin
        res_is_prime_nxt = mem_rdata[0];
        res_oor_nxt      = 1'b0;
        if (load_ok) begin
          out_load         = 1'b1;
          out_is_prime_nxt = mem_rdata[0];
          out_oor_nxt      = 1'b0;
          out_count_nxt    = primes_found_r;
        end
      end
      S_RESP: begin
        if (load_ok) begin
          out_load         = 1'b1;
          out_is_prime_nxt = res_is_prime_r;
          out_oor_nxt      = res_oor_r;
          out_count_nxt    = primes_found_r;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cfg_limit_r    <= {FLD_W{1'b1}};
      built_r        <= 1'b0;
      pend_r         <= 1'b0;
      primes_found_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      built_r        <= built_nxt;
      pend_r         <= pend_nxt;
      primes_found_r <= primes_found_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    built_lim_r    <= built_lim_nxt;
    idx_r          <= idx_nxt;
    i_r            <= i_nxt;
    sq_r           <= sq_nxt;
    j_r            <= j_nxt;
    cnt_r          <= cnt_nxt;
    res_is_prime_r <= res_is_prime_nxt;
    res_oor_r      <= res_oor_nxt;
    out_is_prime_r <= out_is_prime_nxt;
    out_oor_r      <= out_oor_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_is_prime     = out_is_prime_r;
  assign out_out_of_range = out_oor_r;
  assign out_prime_count  = out_count_r;

  a_we_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_FILL || state_r == S_MARK))
    else $error("map written outside a build");

  a_we_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) <= 32'(built_lim_r)))
    else $error("map write above build limit");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CNT) |=> $stable(primes_found_r))
    else $error("prime count changed outside counting pass");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_IDLE || state_r == S_QWAIT || state_r == S_RESP))
    else $error("result loaded mid build");

endmodule
